>>> hdl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and constants of the first-fit block allocator
// Table sizes, payload structs, operation codes, sequencer states and the
// control and event groups passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

   localparam int FUNC_W  = 2;
   localparam int BN_W    = 6;
   localparam int AMT_W   = 16;
   localparam int GRANT_W = 6;
   localparam int NUM_W   = 7;
   localparam int SIZE_W  = 16;
   localparam int FREE_W  = 32;
   localparam int CW      = (CNT_W > NUM_W) ? CNT_W : NUM_W;

   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BLOCKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE = 1'd1;

   localparam logic [NUM_W-1:0]  NUM_RESET  = 7'd64;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd4096;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MERGE   = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BN_W-1:0]   block_number;
      logic [AMT_W-1:0]  amount;
   } ffba_req_type;

   typedef struct packed {
      logic               status;
      logic [GRANT_W-1:0] granted_block;
   } ffba_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REL_RD,
      ST_REL_WR,
      ST_FLUSH,
      ST_DONE
   } ffba_state_type;

   typedef struct packed {
      logic idle;
      logic scan;
      logic rel_rd;
      logic rel_wr;
      logic flush;
      logic finish;
   } ffba_ctrl_type;

   typedef struct packed {
      logic is_merge;
      logic scan_end;
      logic alloc_hit;
      logic rel_ok;
      logic rsp_free;
   } ffba_evt_type;

   function automatic logic [CW-1:0] eff_count(input logic [NUM_W-1:0] n);
      logic [CW-1:0] nw;
      nw = CW'(n);
      return (nw < CW'(MAX_BLOCKS)) ? nw : CW'(MAX_BLOCKS);
   endfunction

   function automatic logic [MAX_BLOCKS-1:0] present_mask(input logic [NUM_W-1:0] n);
      logic [MAX_BLOCKS-1:0] m;
      logic [CW-1:0]         e;
      e = eff_count(n);
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         m[i] = (CW'(i) < e);
      end
      return m;
   endfunction

endpackage

>>> hdl/first_fit_block_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit: first-fit allocator over a block table
// Requests (allocate, release, merge) enter on req_valid/req_ready; each
// produces one result beat on rsp_valid/rsp_ready (status, granted block).
// Registers num_blocks (index 0) and block size (index 1) are written on the
// csr port by the user only while idle (not enforced); each reinitializes the table.
// Free counts live in a RAM with one read and one write port; per-entry
// present and written bits sit in flops, an unwritten entry reads as the
// block size, so reset and register writes take effect at once.
// Allocate and merge walk the table one entry per cycle through the RAM read
// port, then merge flushes its open run. Release reads its entry and writes it
// back (skipped when rejected); an unused operation code finishes at once.
// One request is in flight at a time; req_ready is high only while idle.
// A finished result waits in the output register while the receiver stalls,
// and the next request is accepted meanwhile; it completes only once that
// register is free. Reset restores 64 blocks of 4096 units.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit
   import ffba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ffba_req_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ffba_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ffba_ctrl_type ctrl;
   ffba_evt_type  evt;

   logic [NUM_W-1:0]      num_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [MAX_BLOCKS-1:0] present_ff, present_in;
   logic [MAX_BLOCKS-1:0] written_ff, written_in;

   ffba_req_type      op_ff, op_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]  p_idx_ff, p_idx_in;
   logic              p_wr_ff, p_wr_in;
   logic              cur_vld_ff, cur_vld_in;
   logic [IDX_W-1:0]  cur_idx_ff, cur_idx_in;
   logic [FREE_W-1:0] acc_ff, acc_in;
   logic              res_status_ff, res_status_in;
   logic [GRANT_W-1:0] res_grant_ff, res_grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffba_rsp_type      rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic [NUM_W-1:0]  num_src;
   logic [IDX_W-1:0]  scan_idx;
   logic [IDX_W-1:0]  bn_idx;
   logic              scan_live;
   logic [FREE_W-1:0] fval;
   logic [FREE_W-1:0] amt_ext;
   logic              alloc_fit;
   logic [FREE_W-1:0] alloc_rem;
   logic [FREE_W:0]   mrg_sum;
   logic              mrg_fit;
   logic [FREE_W:0]   rel_sum;
   logic [FREE_W-1:0] rel_sat;
   logic              is_merge;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [FREE_W-1:0] ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   logic [FREE_W-1:0] ram_q;

   ffba_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (FREE_W),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   ffba_fsm u_fsm (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_func (req_data.func),
      .evt      (evt),
      .ctrl     (ctrl)
   );

   assign req_ready = ctrl.idle;
   assign req_fire  = req_valid && ctrl.idle;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign scan_idx  = idx_ff[IDX_W-1:0];
   assign bn_idx    = IDX_W'(op_ff.block_number);
   assign scan_live = (idx_ff != CNT_W'(MAX_BLOCKS));
   assign is_merge  = (op_ff.func == FUNC_MERGE);

   // entries never written since init hold the block size
   assign fval      = p_wr_ff ? ram_q : FREE_W'(size_ff);
   assign amt_ext   = FREE_W'(op_ff.amount);
   assign alloc_fit = (fval >= amt_ext);
   assign alloc_rem = fval - amt_ext;
   assign mrg_sum   = {1'b0, acc_ff} + {1'b0, fval};
   assign mrg_fit   = (mrg_sum <= (FREE_W + 1)'(size_ff));
   assign rel_sum   = {1'b0, fval} + {1'b0, amt_ext};
   assign rel_sat   = rel_sum[FREE_W] ? '1 : rel_sum[FREE_W-1:0];

   assign num_src = (csr_we && csr_index == CSR_NUM_BLOCKS) ?
                    csr_wdata[NUM_W-1:0] : num_ff;

   always_comb begin
      evt.is_merge  = is_merge;
      evt.scan_end  = !scan_live && !p_vld_ff;
      evt.alloc_hit = ctrl.scan && !is_merge && p_vld_ff && alloc_fit;
      evt.rel_ok    = (CW'(op_ff.block_number) < eff_count(num_ff)) &&
                      (op_ff.amount <= size_ff) && present_ff[bn_idx];
      evt.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = scan_idx;
      p_wr_in       = written_ff[scan_idx];
      cur_vld_in    = cur_vld_ff;
      cur_idx_in    = cur_idx_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      present_in    = present_ff;
      written_in    = written_ff;
      ram_raddr     = scan_idx;
      ram_we        = 1'b0;
      ram_waddr     = cur_idx_ff;
      ram_wdata     = acc_ff;

      if (req_fire) begin
         op_in         = req_data;
         idx_in        = '0;
         cur_vld_in    = 1'b0;
         res_status_in = (req_data.func != FUNC_MERGE);
         res_grant_in  = '0;
      end

      if (ctrl.scan) begin
         // issue side: read the next entry if it is present
         if (scan_live) begin
            p_vld_in = present_ff[scan_idx];
            idx_in   = idx_ff + CNT_W'(1);
         end
         // evaluate side: entry read in the previous cycle
         if (p_vld_ff) begin
            if (is_merge) begin
               if (!cur_vld_ff) begin
                  cur_vld_in = 1'b1;
                  cur_idx_in = p_idx_ff;
                  acc_in     = fval;
               end else if (mrg_fit) begin
                  acc_in               = mrg_sum[FREE_W-1:0];
                  present_in[p_idx_ff] = 1'b0;
               end else begin
                  ram_we                 = 1'b1;
                  written_in[cur_idx_ff] = 1'b1;
                  cur_idx_in             = p_idx_ff;
                  acc_in                 = fval;
               end
            end else if (alloc_fit) begin
               ram_we               = 1'b1;
               ram_waddr            = p_idx_ff;
               ram_wdata            = alloc_rem;
               written_in[p_idx_ff] = 1'b1;
               if (alloc_rem == '0) begin
                  present_in[p_idx_ff] = 1'b0;
               end
               res_status_in = 1'b0;
               res_grant_in  = GRANT_W'(p_idx_ff);
            end
         end
      end

      if (ctrl.rel_rd) begin
         ram_raddr = bn_idx;
         p_wr_in   = written_ff[bn_idx];
      end

      if (ctrl.rel_wr) begin
         ram_we             = 1'b1;
         ram_waddr          = bn_idx;
         ram_wdata          = rel_sat;
         written_in[bn_idx] = 1'b1;
         res_status_in      = 1'b0;
      end

      if (ctrl.flush && cur_vld_ff) begin
         ram_we                 = 1'b1;
         written_in[cur_idx_ff] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.finish && evt.rsp_free) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.status        = res_status_ff;
         rsp_data_in.granted_block = res_grant_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= NUM_RESET;
         size_ff      <= SIZE_RESET;
         present_ff   <= present_mask(NUM_RESET);
         written_ff   <= '0;
         p_vld_ff     <= 1'b0;
         cur_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_BLOCKS) begin
               num_ff <= csr_wdata[NUM_W-1:0];
            end
            if (csr_index == CSR_BLOCK_SIZE) begin
               size_ff <= csr_wdata[SIZE_W-1:0];
            end
            present_ff <= present_mask(num_src);
            written_ff <= '0;
         end else begin
            present_ff <= present_in;
            written_ff <= written_in;
         end
         p_vld_ff     <= p_vld_in;
         cur_vld_ff   <= cur_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      p_idx_ff      <= p_idx_in;
      p_wr_ff       <= p_wr_in;
      cur_idx_ff    <= cur_idx_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

>>> hdl/ffba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ffba_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_fsm: allocator sequencer
// Steps one request through the table scan, the release read-modify-write,
// the merge flush and the hand-off to the result register.
// ----------------------------------------------------------------------------
module ffba_fsm
   import ffba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic [FUNC_W-1:0] req_func,
   input  ffba_evt_type      evt,
   output ffba_ctrl_type     ctrl
);

   ffba_state_type state_ff;
   ffba_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  FUNC_ALLOC:   state_in = ST_SCAN;
                  FUNC_MERGE:   state_in = ST_SCAN;
                  FUNC_RELEASE: state_in = ST_REL_RD;
                  default:      state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (evt.alloc_hit) begin
               state_in = ST_DONE;
            end else if (evt.scan_end) begin
               state_in = evt.is_merge ? ST_FLUSH : ST_DONE;
            end
         end
         ST_REL_RD: begin
            state_in = evt.rel_ok ? ST_REL_WR : ST_DONE;
         end
         ST_REL_WR: state_in = ST_DONE;
         ST_FLUSH:  state_in = ST_DONE;
         ST_DONE: begin
            if (evt.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:   ctrl.idle   = 1'b1;
         ST_SCAN:   ctrl.scan   = 1'b1;
         ST_REL_RD: ctrl.rel_rd = 1'b1;
         ST_REL_WR: ctrl.rel_wr = 1'b1;
         ST_FLUSH:  ctrl.flush  = 1'b1;
         ST_DONE:   ctrl.finish = 1'b1;
         default:   ctrl        = '0;
      endcase
   end

endmodule
